/* rtl/core/pidl_pkg.sv */
// shared types and constants for the positional insert/delete list
package pidl_pkg;

    localparam int CAPACITY = 128;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 8;
    localparam int FILL_W   = 8;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int GRP      = 8;
    localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_READ   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_BADPOS    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_EXEC = 2'd1,
        PH_FIN  = 2'd2
    } phase_t;

    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic                     rd;
        logic [IDX_W-1:0]         slot;
        logic signed [DATA_W-1:0] value;
    } cell_ctl_t;

endpackage

/* rtl/core/pidl_req_if.sv */
// request channel: operation kind, position and value
interface pidl_req_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        kind;
    logic [pidl_pkg::POS_W-1:0]        position;
    logic signed [pidl_pkg::DATA_W-1:0] value;

    modport source (output valid, output kind, output position, output value, input ready);
    modport sink   (input valid, input kind, input position, input value, output ready);
endinterface

/* rtl/core/pidl_rsp_if.sv */
// response channel: status, value read and fill count
interface pidl_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        status;
    logic signed [pidl_pkg::DATA_W-1:0] read_value;
    logic [pidl_pkg::FILL_W-1:0]       fill_count;

    modport source (output valid, output status, output read_value, output fill_count,
                    input ready);
    modport sink   (input valid, input status, input read_value, input fill_count,
                    output ready);
endinterface

/* rtl/core/positional_insert_delete_list.sv */
// top level: ordered list of signed words with positional insert, delete and read
//
// The list is a row of CAPACITY cells, each holding one 32-bit entry. An insert
// at position p makes every cell above slot p-1 take its lower neighbor's entry
// and cell p-1 take the new value; a delete makes every cell from slot p-1 up take
// its upper neighbor's entry. All cells move on the same clock edge, wherever in
// the list the shift lands. Each request transfer yields exactly one response
// transfer carrying a status (ok, overflow on a full insert, underflow on an empty
// delete, bad position), the entry read for an ok read (zero otherwise) and the
// fill count after the operation, masked to 8 bits. One operation is in flight at
// a time and it goes through three steps: accept, execute (status decision, cell
// shift, first level of the read or-tree in 16 groups of 8) and finish (second
// level of the or-tree into the response register). A new request is taken only
// after the previous one has finished. Entries past the fill count are never
// read, so the cells need no clearing after reset.
module positional_insert_delete_list (
    input  logic              clk,
    input  logic              rst_n,
    pidl_req_if.sink          req,
    pidl_rsp_if.source        rsp
);

    // control state
    pidl_pkg::phase_t                   phase_reg, phase_next;
    logic [pidl_pkg::CNT_W-1:0]         count_reg, count_next;
    logic                               rsp_valid_reg, rsp_valid_next;

    // captured request
    pidl_pkg::kind_t                    kind_reg;
    logic [pidl_pkg::POS_W-1:0]         pos_reg;
    logic signed [pidl_pkg::DATA_W-1:0] value_reg;

    // decided in execute, shown in finish
    pidl_pkg::status_t                  status_reg, status_next;

    // response register
    pidl_pkg::status_t                  rsp_status_reg;
    logic signed [pidl_pkg::DATA_W-1:0] rsp_value_reg;
    logic [pidl_pkg::FILL_W-1:0]        rsp_fill_reg;

    logic                               req_xfer;
    logic                               rsp_load;
    logic                               do_ins, do_del, do_rd;
    logic [pidl_pkg::CMP_W-1:0]         pos_w, cnt_w;
    logic [pidl_pkg::CMP_W-1:0]         slot_w;
    pidl_pkg::cell_ctl_t                ctl;

    logic signed [pidl_pkg::DATA_W-1:0] cell_entry [pidl_pkg::CAPACITY];
    logic signed [pidl_pkg::DATA_W-1:0] cell_rd    [pidl_pkg::CAPACITY];
    logic signed [pidl_pkg::DATA_W-1:0] tree_value;

    assign req.ready = (phase_reg == pidl_pkg::PH_IDLE);
    assign req_xfer  = req.valid && req.ready;

    // range checks run on a common width wide enough for position and count+1
    assign pos_w  = pidl_pkg::CMP_W'(pos_reg);
    assign cnt_w  = pidl_pkg::CMP_W'(count_reg);
    assign slot_w = pos_w - pidl_pkg::CMP_W'(1);

    // status decision and cell commands
    always_comb
    begin
        status_next = pidl_pkg::ST_OK;
        do_ins      = 1'b0;
        do_del      = 1'b0;
        do_rd       = 1'b0;
        case (kind_reg)
            pidl_pkg::KIND_INSERT:
            begin
                if (cnt_w >= pidl_pkg::CMP_W'(pidl_pkg::CAPACITY))
                    status_next = pidl_pkg::ST_OVERFLOW;
                else if ((pos_w == '0) || (pos_w > cnt_w + pidl_pkg::CMP_W'(1)))
                    status_next = pidl_pkg::ST_BADPOS;
                else
                    do_ins = 1'b1;
            end
            pidl_pkg::KIND_DELETE:
            begin
                if (cnt_w == '0)
                    status_next = pidl_pkg::ST_UNDERFLOW;
                else if ((pos_w == '0) || (pos_w > cnt_w))
                    status_next = pidl_pkg::ST_BADPOS;
                else
                    do_del = 1'b1;
            end
            pidl_pkg::KIND_READ:
            begin
                if ((pos_w == '0) || (pos_w > cnt_w))
                    status_next = pidl_pkg::ST_BADPOS;
                else
                    do_rd = 1'b1;
            end
            default:
            begin
                // unused code: no change, ok status
                status_next = pidl_pkg::ST_OK;
            end
        endcase
    end

    // commands reach the cells only during execute
    always_comb
    begin
        ctl.ins   = do_ins && (phase_reg == pidl_pkg::PH_EXEC);
        ctl.del   = do_del && (phase_reg == pidl_pkg::PH_EXEC);
        ctl.rd    = do_rd  && (phase_reg == pidl_pkg::PH_EXEC);
        ctl.slot  = slot_w[pidl_pkg::IDX_W-1:0];
        ctl.value = value_reg;
    end

    // row of cells; the ends see zero from the missing neighbor
    for (genvar g = 0; g < pidl_pkg::CAPACITY; g++)
    begin : g_cell
        logic signed [pidl_pkg::DATA_W-1:0] left_in;
        logic signed [pidl_pkg::DATA_W-1:0] right_in;

        if (g == 0)
        begin : g_first
            assign left_in = '0;
        end
        else
        begin : g_mid_l
            assign left_in = cell_entry[g-1];
        end

        if (g == pidl_pkg::CAPACITY - 1)
        begin : g_last
            assign right_in = '0;
        end
        else
        begin : g_mid_r
            assign right_in = cell_entry[g+1];
        end

        pidl_cell u_cell (
            .clk         (clk),
            .cell_index  (pidl_pkg::IDX_W'(g)),
            .ctl         (ctl),
            .left_entry  (left_in),
            .right_entry (right_in),
            .entry       (cell_entry[g]),
            .rd_data     (cell_rd[g])
        );
    end

    pidl_read_tree u_read_tree (
        .clk      (clk),
        .capture  (phase_reg == pidl_pkg::PH_EXEC),
        .cell_rd  (cell_rd),
        .rd_value (tree_value)
    );

    // sequencing and count update
    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        rsp_load       = 1'b0;
        rsp_valid_next = rsp_valid_reg;
        if (rsp.ready)
            rsp_valid_next = 1'b0;
        case (phase_reg)
            pidl_pkg::PH_IDLE:
            begin
                if (req_xfer)
                    phase_next = pidl_pkg::PH_EXEC;
            end
            pidl_pkg::PH_EXEC:
            begin
                if (do_ins)
                    count_next = count_reg + pidl_pkg::CNT_W'(1);
                else if (do_del)
                    count_next = count_reg - pidl_pkg::CNT_W'(1);
                phase_next = pidl_pkg::PH_FIN;
            end
            pidl_pkg::PH_FIN:
            begin
                // wait here while an older response is still not taken
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_load       = 1'b1;
                    rsp_valid_next = 1'b1;
                    phase_next     = pidl_pkg::PH_IDLE;
                end
            end
            default:
            begin
                phase_next = pidl_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= pidl_pkg::PH_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            kind_reg  <= pidl_pkg::kind_t'(req.kind);
            pos_reg   <= req.position;
            value_reg <= req.value;
        end
        if (phase_reg == pidl_pkg::PH_EXEC)
            status_reg <= status_next;
        if (rsp_load)
        begin
            rsp_status_reg <= status_reg;
            rsp_value_reg  <= tree_value;
            rsp_fill_reg   <= pidl_pkg::FILL_W'(count_reg);
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.read_value = rsp_value_reg;
    assign rsp.fill_count = rsp_fill_reg;

endmodule

/* rtl/core/pidl_cell.sv */
// one list slot: holds an entry and shifts toward either neighbor
module pidl_cell (
    input  logic                               clk,
    input  logic [pidl_pkg::IDX_W-1:0]         cell_index,
    input  pidl_pkg::cell_ctl_t                ctl,
    input  logic signed [pidl_pkg::DATA_W-1:0] left_entry,
    input  logic signed [pidl_pkg::DATA_W-1:0] right_entry,
    output logic signed [pidl_pkg::DATA_W-1:0] entry,
    output logic signed [pidl_pkg::DATA_W-1:0] rd_data
);

    logic signed [pidl_pkg::DATA_W-1:0] entry_reg;
    logic signed [pidl_pkg::DATA_W-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ins)
        begin
            if (cell_index > ctl.slot)
                entry_next = left_entry;
            else if (cell_index == ctl.slot)
                entry_next = ctl.value;
        end
        else if (ctl.del && (cell_index >= ctl.slot))
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry   = entry_reg;
    assign rd_data = (ctl.rd && (cell_index == ctl.slot)) ? entry_reg : '0;

endmodule

/* rtl/core/pidl_read_tree.sv */
// two-level or-tree gathering the selected cell's entry
module pidl_read_tree (
    input  logic                               clk,
    input  logic                               capture,
    input  logic signed [pidl_pkg::DATA_W-1:0] cell_rd [pidl_pkg::CAPACITY],
    output logic signed [pidl_pkg::DATA_W-1:0] rd_value
);

    logic signed [pidl_pkg::DATA_W-1:0] grp_reg  [pidl_pkg::NGRP];
    logic signed [pidl_pkg::DATA_W-1:0] grp_next [pidl_pkg::NGRP];

    always_comb
    begin
        for (int g = 0; g < pidl_pkg::NGRP; g++)
        begin
            grp_next[g] = '0;
            for (int j = 0; j < pidl_pkg::GRP; j++)
            begin
                if (g * pidl_pkg::GRP + j < pidl_pkg::CAPACITY)
                    grp_next[g] = grp_next[g] | cell_rd[g * pidl_pkg::GRP + j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            for (int g = 0; g < pidl_pkg::NGRP; g++)
                grp_reg[g] <= grp_next[g];
        end
    end

    always_comb
    begin
        rd_value = '0;
        for (int g = 0; g < pidl_pkg::NGRP; g++)
            rd_value = rd_value | grp_reg[g];
    end

endmodule

/* rtl/core/pidl_checker.sv */
// port-level checks for the positional insert/delete list, bound to the top level
module pidl_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    input  logic                               req_ready,
    input  logic                               rsp_valid,
    input  logic                               rsp_ready,
    input  logic [1:0]                         rsp_status,
    input  logic signed [pidl_pkg::DATA_W-1:0] rsp_read_value,
    input  logic [pidl_pkg::FILL_W-1:0]        rsp_fill_count
);

    // a stalled response keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_read_value) && $stable(rsp_fill_count))
    else $error("stalled response changed");

    // one operation at a time: no new request right after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

    // overflow only on a full list
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == pidl_pkg::ST_OVERFLOW)
            |-> rsp_fill_count == pidl_pkg::FILL_W'(pidl_pkg::CAPACITY))
    else $error("overflow with room left");

    // underflow only on an empty list
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == pidl_pkg::ST_UNDERFLOW) |-> rsp_fill_count == '0)
    else $error("underflow on a non-empty list");

    // a nonzero read value comes only with an ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_read_value != '0) |-> rsp_status == pidl_pkg::ST_OK)
    else $error("read value on a failed operation");

endmodule

bind positional_insert_delete_list pidl_checker u_pidl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_read_value (rsp.read_value),
    .rsp_fill_count (rsp.fill_count)
);
